// ===== rtl/fmis_pkg.sv =====
// ----------------------------------------------------------------------------
// fmis_pkg
// Shared constants and register codes for the first-match index sum block.
// ----------------------------------------------------------------------------
package fmis_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_TEXT    = 65536;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 4;                      // pattern_length register width
  localparam int CNT_W   = 4;                      // matched byte count
  localparam int IDX_W   = $clog2(MAX_PATTERN);    // window / pattern byte index
  localparam int POS_W   = $clog2(MAX_TEXT);       // text position
  localparam int RSUM_W  = 20;                     // running subsequence sum
  localparam int SUM_W   = 19;                     // reported index sum
  localparam int PROD_W  = LEN_W + POS_W;          // len * position
  localparam int PAT_W   = MAX_PATTERN * BYTE_W;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_MODE     = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_PATTERN_BYTES  = 2'd2
  } cfg_reg_e;

endpackage

// ===== rtl/first_match_index_sum_top.sv =====
// ----------------------------------------------------------------------------
// first_match_index_sum_top
// Finds the first match of a short pattern in a byte stream and reports the
// sum of the text positions of the matched bytes.
//
// Text bytes stream in on the slave side, one per transaction, with tlast on
// the final byte of each text; positions count from 0 in every text and
// saturate at MAX_TEXT-1. In substring mode the newest bytes are compared in
// parallel against the pattern and the first contiguous hit ending at p
// reports L*p - L*(L-1)/2. In subsequence mode pattern bytes are matched
// greedily in order and the hit reports the sum of their positions. At most
// one result per text; after a hit the bytes are ignored until tlast, which
// rearms the block. The block takes one byte every cycle while no result is
// held back by m_axis_tready; each byte waits in the input register while the
// window compare and sum update run into the result register, and the state
// loop through that compare and update sets the one-byte-per-cycle rate. A
// result held by m_axis_tready keeps one more byte in the input register and
// then drops s_axis_tready until the result transaction is taken. Registers
// are to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module first_match_index_sum_top
  import fmis_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [PAT_W-1:0]       cfg_data_i,
  // text stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic                   s_axis_tlast,   // last_byte
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [18:0] index_sum, rest zero
);

  // Configuration registers
  logic                 mode_q;
  logic [LEN_W-1:0]     plen_q;
  logic [PAT_W-1:0]     pat_q;

  // Input register
  logic                 in_valid_q;
  logic [BYTE_W-1:0]    in_byte_q;
  logic                 in_last_q;

  // Per-text state
  logic [BYTE_W-1:0]    win_q [MAX_PATTERN];
  logic [POS_W-1:0]     pos_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [RSUM_W-1:0]    rsum_q;
  logic                 done_q;

  // Result register
  logic                 out_valid_q;
  logic [SUM_W-1:0]     out_sum_q;

  // Compute stage
  logic                 fire;
  logic [LEN_W-1:0]     len;
  logic [BYTE_W-1:0]    win_d [MAX_PATTERN];
  logic                 sub_hit;
  logic                 seq_hit;
  logic                 take;
  logic [IDX_W-1:0]     cnt_idx;
  logic [IDX_W-1:0]     win_idx;
  logic [CNT_W-1:0]     cnt_d;
  logic [RSUM_W-1:0]    rsum_d;
  logic [PROD_W-1:0]    prod;
  logic [2*LEN_W-1:0]   tri_off;
  logic [PROD_W-1:0]    sub_sum;
  logic                 hit;
  logic [SUM_W-1:0]     result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      plen_q <= LEN_W'(1);
      pat_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MATCH_MODE:     mode_q <= cfg_data_i[0];
        REG_PATTERN_LENGTH: plen_q <= cfg_data_i[LEN_W-1:0];
        REG_PATTERN_BYTES:  pat_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Compute fires when a byte waits and the result register is free.
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[BYTE_W-1:0];
      in_last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    // effective pattern length, clamped to 1..MAX_PATTERN
    len = plen_q;
    if (plen_q == '0) begin
      len = LEN_W'(1);
    end else if (plen_q > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end

    // shifted window, newest byte in entry 0
    win_d[0] = in_byte_q;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_d[k] = win_q[k-1];
    end

    // substring: pattern byte i against window entry len-1-i
    sub_hit = ((POS_W+1)'(pos_q) + (POS_W+1)'(1)) >= (POS_W+1)'(len);
    win_idx = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_idx = IDX_W'(len - LEN_W'(1) - LEN_W'(i));
      if ((LEN_W'(i) < len) && (win_d[win_idx] != pat_q[BYTE_W*i +: BYTE_W])) begin
        sub_hit = 1'b0;
      end
    end

    // subsequence: greedy in-order match
    cnt_idx = cnt_q[IDX_W-1:0];
    take    = (cnt_q < CNT_W'(len)) && (in_byte_q == pat_q[BYTE_W*cnt_idx +: BYTE_W]);
    cnt_d   = take ? cnt_q + CNT_W'(1) : cnt_q;
    rsum_d  = take ? rsum_q + RSUM_W'(pos_q) : rsum_q;
    seq_hit = cnt_d >= CNT_W'(len);

    // L*p - L*(L-1)/2
    prod    = PROD_W'(len) * PROD_W'(pos_q);
    tri_off = ((2*LEN_W)'(len) * (2*LEN_W)'(len - LEN_W'(1))) >> 1;
    sub_sum = prod - PROD_W'(tri_off);

    hit    = mode_q ? seq_hit : sub_hit;
    result = mode_q ? SUM_W'(rsum_d) : SUM_W'(sub_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= '0;
      end
      pos_q  <= '0;
      cnt_q  <= '0;
      rsum_q <= '0;
      done_q <= 1'b0;
    end else if (fire) begin
      if (in_last_q) begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
          win_q[k] <= '0;
        end
        pos_q  <= '0;
        cnt_q  <= '0;
        rsum_q <= '0;
        done_q <= 1'b0;
      end else if (!done_q) begin
        win_q  <= win_d;
        cnt_q  <= cnt_d;
        rsum_q <= rsum_d;
        done_q <= hit;
        if (pos_q < POS_W'(MAX_TEXT - 1)) begin
          pos_q <= pos_q + POS_W'(1);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && !done_q && hit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !done_q && hit) begin
      out_sum_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_sum_q);

endmodule

// ===== rtl/fmis_checker.sv =====
// ----------------------------------------------------------------------------
// fmis_checker
// Port-level checks for the first-match index sum block.
// ----------------------------------------------------------------------------
module fmis_checker
  import fmis_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // sum never exceeds its field
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:SUM_W] == '0))
    else $error("padding bits set");

  // input register plus stalled result register: no room for a third byte
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready)
      |=> (m_axis_tready || !s_axis_tready))
    else $error("byte taken with both stages full");

endmodule

bind first_match_index_sum_top fmis_checker u_fmis_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/first_match_index_sum_top_tb.sv =====
// ----------------------------------------------------------------------------
// first_match_index_sum_top_tb
// Streams texts into the block and checks every reported index sum against a
// cycle-free model of the substring and subsequence search. Covers register
// extremes and length clamping, short texts, mid-text mode changes, ignored
// bytes after a hit, random idling on both sides and a long result-side hold
// that backs up the text input.
// ----------------------------------------------------------------------------
module first_match_index_sum_top_tb;
  import fmis_pkg::*;

  localparam int SETTLE_CYCLES = 8;     // idle tail in wait_idle
  localparam int HOLD_CYCLES   = 400;   // long result-side hold-off
  localparam int PHASE_BYTES   = 160;   // random bytes per register setting
  localparam int NUM_PHASES    = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [PAT_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  first_match_index_sum_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Search model: register copies and per-text state
  // --------------------------------------------------------------------------
  logic             mode_r = 1'b0;
  logic [3:0]       plen_r = 4'd1;
  logic [PAT_W-1:0] pat_r  = '0;

  logic [7:0]  win_q [MAX_PATTERN];   // entry 0 is the newest byte
  int unsigned txt_pos  = 0;
  int unsigned seq_cnt  = 0;
  int unsigned seq_sum  = 0;
  bit          sum_done = 1'b0;

  text_item_t       text_q [$];       // bytes waiting for the driver
  logic [SUM_W-1:0] pending_sums [$]; // index sums still to arrive

  bit          idle_on = 1'b0;
  int          n_errors = 0;
  int unsigned n_bytes = 0;
  int unsigned sums_checked = 0;
  int unsigned n_cfg = 0;

  initial foreach (win_q[k]) win_q[k] = '0;

  function automatic int unsigned eff_len();
    if (plen_r == 0) return 1;
    if (plen_r > MAX_PATTERN) return MAX_PATTERN;
    return plen_r;
  endfunction

  function automatic logic [7:0] pat_at(input int unsigned k);
    return pat_r[8*k +: 8];
  endfunction

  // Both searches advance on every byte; match_mode only picks which one
  // reports. After a hit nothing moves until the byte marked last.
  function automatic bit predict_index_sum(input logic [7:0] c, input logic last,
                                           output logic [SUM_W-1:0] sum);
    int unsigned len, pos, k;
    bit          sub_hit, emit;
    emit = 1'b0;
    sum  = '0;
    if (!sum_done) begin
      len = eff_len();
      pos = txt_pos;
      for (k = MAX_PATTERN - 1; k > 0; k--) win_q[k] = win_q[k-1];
      win_q[0] = c;
      sub_hit = (pos + 1 >= len);
      for (k = 0; k < len; k++)
        if (win_q[len-1-k] != pat_at(k)) sub_hit = 1'b0;
      if (seq_cnt < len && c == pat_at(seq_cnt)) begin
        seq_sum = (seq_sum + pos) & ((1 << RSUM_W) - 1);
        seq_cnt++;
      end
      if (!mode_r && sub_hit) begin
        emit = 1'b1;
        sum  = SUM_W'(len * pos - len * (len - 1) / 2);
      end else if (mode_r && seq_cnt >= len) begin
        emit = 1'b1;
        sum  = SUM_W'(seq_sum);
      end
      if (emit) sum_done = 1'b1;
      if (txt_pos < MAX_TEXT - 1) txt_pos++;
    end
    if (last) begin
      foreach (win_q[k]) win_q[k] = '0;
      txt_pos  = 0;
      seq_cnt  = 0;
      seq_sum  = 0;
      sum_done = 1'b0;
    end
    return emit;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Text driver: one byte per transaction, fed from text_q
  // --------------------------------------------------------------------------
  int unsigned tx_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin : text_drv
    text_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap        <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        tx_gap        <= tx_gap - 1;
      end else if (text_q.size() != 0) begin
        nxt = text_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.ch;
        s_axis_tlast  <= nxt.last;
        tx_gap        <= gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold while the text queue is
  // well stocked so the block backs up and drops s_axis_tready
  // --------------------------------------------------------------------------
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else if (!hold_done && sums_checked >= 8 && text_q.size() >= 120) begin
      m_axis_tready <= 1'b0;
      hold_done     <= 1'b1;
      rx_hold       <= HOLD_CYCLES;
    end else if (rx_gap != 0) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= rx_gap - 1;
    end else if (idle_on && $urandom_range(0, 99) < 15) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                   : $urandom_range(8, 40);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results, then predict from the accepted text byte
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    logic [SUM_W-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index_sum %0d",
                   $time, m_axis_tdata);
          n_errors++;
        end else begin
          want = pending_sums.pop_front();
          if (m_axis_tdata !== OUT_TDATA_W'(want)) begin
            $display("%0t: index_sum mismatch, expected %0d, actual %0d",
                     $time, want, m_axis_tdata);
            n_errors++;
          end
        end
        sums_checked <= sums_checked + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_index_sum(s_axis_tdata, s_axis_tlast, want))
          pending_sums.push_back(want);
        n_bytes++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_e idx, input logic [PAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MATCH_MODE:     mode_r = val[0];
      REG_PATTERN_LENGTH: plen_r = val[3:0];
      default:            pat_r  = val;
    endcase
    n_cfg++;
  endtask

  // Block is idle: nothing queued or offered, all sums back, tail settled.
  task automatic wait_idle();
    while (text_q.size() != 0 || s_axis_tvalid || pending_sums.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] c, input logic last);
    text_q.push_back('{ch: c, last: last});
  endtask

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return pat_at($urandom_range(0, eff_len() - 1));
  endfunction

  // One text: mostly the pattern embedded in pattern-rich filler (spread out
  // in subsequence mode), some with one pattern byte corrupted, some noise.
  task automatic gen_text(output int unsigned n_items);
    logic [7:0]  chars_q [$];
    int unsigned len, kind, bad, j;
    bit          ends;
    len  = eff_len();
    kind = $urandom_range(0, 9);
    ends = 1'b1;
    if (kind >= 8) begin
      repeat ($urandom_range(1, 12)) chars_q.push_back(8'($urandom_range(0, 255)));
      ends = ($urandom_range(0, 4) != 0);
    end else begin
      bad = (kind >= 6) ? $urandom_range(0, len - 1) : len;
      repeat ($urandom_range(0, 6)) chars_q.push_back(text_char());
      for (j = 0; j < len; j++) begin
        if (j == bad) chars_q.push_back(pat_at(j) ^ 8'($urandom_range(1, 255)));
        else          chars_q.push_back(pat_at(j));
        if (mode_r && j + 1 < len)
          repeat ($urandom_range(0, 2)) chars_q.push_back(text_char());
      end
      repeat ($urandom_range(0, 4)) chars_q.push_back(text_char());
    end
    n_items = chars_q.size();
    for (j = 0; j < n_items; j++)
      push_byte(chars_q[j], ends && j == n_items - 1);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    int unsigned ph, got, phase_items, k;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset registers: length 1, pattern byte zero, substring mode
    push_byte(8'h5A, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();

    // length above the maximum clamps to 8, all-ones pattern, subsequence
    write_reg(REG_MATCH_MODE, 1);
    write_reg(REG_PATTERN_LENGTH, 15);
    write_reg(REG_PATTERN_BYTES, '1);
    for (k = 0; k < 8; k++) push_byte(8'hFF, k == 7);
    wait_idle();

    // length zero acts as one; then a text shorter than the pattern
    write_reg(REG_MATCH_MODE, 0);
    write_reg(REG_PATTERN_LENGTH, 0);
    write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6241);
    push_byte(8'h41, 1'b1);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 3);
    push_byte(8'h41, 1'b0);
    push_byte(8'h62, 1'b1);
    wait_idle();

    // subsequence already complete in substring mode, switch mode mid text:
    // the next byte reports the subsequence sum
    write_reg(REG_PATTERN_LENGTH, 2);
    write_reg(REG_PATTERN_BYTES, 64'h2211);
    push_byte(8'h11, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h22, 1'b0);
    wait_idle();
    write_reg(REG_MATCH_MODE, 1);
    push_byte(8'h44, 1'b1);
    wait_idle();

    // bytes after a hit are ignored until the last byte
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b1);
    wait_idle();

    // random texts under several register settings
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      idle_on = (ph != 3);
      write_reg(REG_MATCH_MODE, (ph < 4) ? PAT_W'(ph[0]) : PAT_W'($urandom_range(0, 1)));
      case (ph)
        0:       write_reg(REG_PATTERN_LENGTH, 15);
        1:       write_reg(REG_PATTERN_LENGTH, 0);
        2:       write_reg(REG_PATTERN_LENGTH, 8);
        3:       write_reg(REG_PATTERN_LENGTH, 1);
        default: write_reg(REG_PATTERN_LENGTH, PAT_W'($urandom_range(1, 8)));
      endcase
      write_reg(REG_PATTERN_BYTES, {$urandom, $urandom});
      phase_items = 0;
      while (phase_items < PHASE_BYTES) begin
        gen_text(got);
        phase_items += got;
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d text bytes, checked %0d index sums, %0d register writes.",
             n_bytes, sums_checked, n_cfg);
    $display("Ran both modes, length clamping, short texts and a long output stall.");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("%0t: timeout, %0d index sums still pending", $time, pending_sums.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
